[rtl/core/dwt_pkg.sv]
// Package for the DMA window table: types, constants and helper functions.
`timescale 1ns / 1ps

package dwt_pkg;

    localparam int ENTRY_COUNT = 16;
    localparam int IDX_W       = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;

    localparam int ADDR_W     = 44;
    localparam int SIZE_W     = 43;
    localparam int FLAGS_W    = 32;
    localparam int PAGE_SHIFT = 12;
    localparam int PAGE_W     = 32;
    localparam int PAGES_W    = 30;
    localparam int CNT_W      = SIZE_W - PAGE_SHIFT;
    localparam int V2_FLAGS_W = 8;
    localparam int V2_PAGES_W = 24;

    localparam logic [1:0] OP_ADD     = 2'd0;
    localparam logic [1:0] OP_REMOVE  = 2'd1;
    localparam logic [1:0] OP_PRELOAD = 2'd2;
    localparam logic [1:0] OP_RELEASE = 2'd3;

    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_NO_FREE      = 3'd1;
    localparam logic [2:0] ST_ADDR_MISALGN = 3'd2;
    localparam logic [2:0] ST_SIZE_MISALGN = 3'd3;
    localparam logic [2:0] ST_SIZE_LARGE   = 3'd4;
    localparam logic [2:0] ST_NOT_FOUND    = 3'd5;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [3:0]         entry_index;
        logic [ADDR_W-1:0]  entry_address;
        logic [SIZE_W-1:0]  entry_size;
        logic [FLAGS_W-1:0] entry_flags;
    } t_in_item;

    typedef struct packed {
        logic [2:0] status;
        logic [3:0] result_index;
    } t_out_item;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_COMMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic eval;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] idx;
    } t_pick;

    function automatic t_pick first_set(input logic [ENTRY_COUNT-1:0] v);
        t_pick p;
        p.found = 1'b0;
        p.idx   = '0;
        for (int i = ENTRY_COUNT - 1; i >= 0; i--) begin
            if (v[i]) begin
                p.found = 1'b1;
                p.idx   = IDX_W'(i);
            end
        end
        return p;
    endfunction

    function automatic logic [FLAGS_W-1:0] stored_flags(input logic layout_v3,
                                                        input logic [FLAGS_W-1:0] f);
        return layout_v3 ? f : {{(FLAGS_W - V2_FLAGS_W){1'b0}}, f[V2_FLAGS_W-1:0]};
    endfunction

    function automatic logic [PAGES_W-1:0] cut_pages(input logic layout_v3,
                                                     input logic [CNT_W-1:0] c);
        return layout_v3 ? c[PAGES_W-1:0]
                         : {{(PAGES_W - V2_PAGES_W){1'b0}}, c[V2_PAGES_W-1:0]};
    endfunction

endpackage

[rtl/core/dwt_ctrl.sv]
// Controller state machine: sequences capture, evaluation and commit of one item.
`timescale 1ns / 1ps

module dwt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    output logic              o_result_valid,
    output dwt_pkg::t_dp_cmd  o_cmd
);

    dwt_pkg::t_state r_state;
    dwt_pkg::t_state n_state;
    logic            r_valid;
    logic            n_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dwt_pkg::S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            dwt_pkg::S_IDLE: begin
                if (start) n_state = dwt_pkg::S_EVAL;
            end
            dwt_pkg::S_EVAL:   n_state = dwt_pkg::S_COMMIT;
            dwt_pkg::S_COMMIT: n_state = dwt_pkg::S_IDLE;
            default:           n_state = dwt_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        busy    = 1'b1;
        n_valid = 1'b0;
        case (r_state)
            dwt_pkg::S_IDLE: begin
                busy       = 1'b0;
                o_cmd.load = start;
            end
            dwt_pkg::S_EVAL: begin
                o_cmd.eval = 1'b1;
            end
            dwt_pkg::S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_valid      = 1'b1;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

    assign o_result_valid = r_valid;

endmodule

[rtl/core/dwt_datapath.sv]
// Datapath: window table, protected mask, per-entry match lanes and commit logic.
`timescale 1ns / 1ps

module dwt_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dwt_pkg::t_dp_cmd    i_cmd,
    input  dwt_pkg::t_in_item   i_item,
    input  logic                i_cfg_wr_en,
    input  logic                i_cfg_wr_data,
    output dwt_pkg::t_out_item  o_result
);

    localparam int N = dwt_pkg::ENTRY_COUNT;

    logic                             r_layout_v3;
    dwt_pkg::t_in_item                r_item;
    logic [dwt_pkg::PAGE_W-1:0]       r_page  [N];
    logic [dwt_pkg::PAGES_W-1:0]      r_pages [N];
    logic [dwt_pkg::FLAGS_W-1:0]      r_flags [N];
    logic [N-1:0]                     r_prot;
    logic [N-1:0]                     r_free;
    logic [N-1:0]                     r_match;
    logic                             r_addr_mis;
    logic                             r_size_mis;
    logic                             r_too_large;
    dwt_pkg::t_out_item               r_result;

    logic [dwt_pkg::PAGE_W-1:0]       page_num;
    logic [dwt_pkg::CNT_W-1:0]        page_cnt;
    logic [dwt_pkg::FLAGS_W-1:0]      flags_st;
    logic                             addr_mis;
    logic                             size_mis;
    logic                             too_large;
    logic [N-1:0]                     free_v;
    logic [N-1:0]                     match_v;

    dwt_pkg::t_pick                   pick_free;
    dwt_pkg::t_pick                   pick_match;
    logic                             wr_en;
    logic                             rel_en;
    logic                             prot_en;
    logic [dwt_pkg::IDX_W-1:0]        wr_idx;
    logic [dwt_pkg::PAGE_W-1:0]       wr_page;
    logic [dwt_pkg::PAGES_W-1:0]      wr_pages;
    logic [dwt_pkg::FLAGS_W-1:0]      wr_flags;
    dwt_pkg::t_out_item               n_result;

    assign page_num  = r_item.entry_address[dwt_pkg::ADDR_W-1:dwt_pkg::PAGE_SHIFT];
    assign page_cnt  = r_item.entry_size[dwt_pkg::SIZE_W-1:dwt_pkg::PAGE_SHIFT];
    assign flags_st  = dwt_pkg::stored_flags(r_layout_v3, r_item.entry_flags);
    assign addr_mis  = |r_item.entry_address[dwt_pkg::PAGE_SHIFT-1:0];
    assign size_mis  = |r_item.entry_size[dwt_pkg::PAGE_SHIFT-1:0];
    assign too_large = r_layout_v3 ? (|page_cnt[dwt_pkg::CNT_W-1:dwt_pkg::PAGES_W])
                                   : (|page_cnt[dwt_pkg::CNT_W-1:dwt_pkg::V2_PAGES_W]);

    always_comb begin
        for (int i = 0; i < N; i++) begin
            free_v[i]  = !r_prot[i] && (r_flags[i] == '0);
            match_v[i] = !addr_mis && !size_mis
                         && (page_num == r_page[i])
                         && (page_cnt == dwt_pkg::CNT_W'(r_pages[i]))
                         && (r_item.entry_flags == r_flags[i]);
        end
    end

    assign pick_free  = dwt_pkg::first_set(r_free);
    assign pick_match = dwt_pkg::first_set(r_match);

    always_comb begin
        wr_en    = 1'b0;
        rel_en   = 1'b0;
        prot_en  = 1'b0;
        wr_idx   = '0;
        wr_page  = page_num;
        wr_pages = dwt_pkg::cut_pages(r_layout_v3, page_cnt);
        wr_flags = flags_st;
        n_result = '{status: dwt_pkg::ST_OK, result_index: 4'd0};
        case (r_item.opcode)
            dwt_pkg::OP_ADD: begin
                if (!pick_free.found) begin
                    n_result.status = dwt_pkg::ST_NO_FREE;
                end else if (r_addr_mis) begin
                    n_result.status = dwt_pkg::ST_ADDR_MISALGN;
                end else if (r_size_mis) begin
                    n_result.status = dwt_pkg::ST_SIZE_MISALGN;
                end else if (r_too_large) begin
                    n_result.status = dwt_pkg::ST_SIZE_LARGE;
                end else begin
                    wr_en                 = 1'b1;
                    wr_idx                = pick_free.idx;
                    n_result.result_index = 4'(pick_free.idx);
                end
            end
            dwt_pkg::OP_REMOVE: begin
                wr_page  = '0;
                wr_pages = '0;
                wr_flags = '0;
                if (!pick_match.found) begin
                    n_result.status = dwt_pkg::ST_NOT_FOUND;
                end else begin
                    wr_en                 = 1'b1;
                    wr_idx                = pick_match.idx;
                    n_result.result_index = 4'(pick_match.idx);
                end
            end
            dwt_pkg::OP_PRELOAD: begin
                if ({28'd0, r_item.entry_index} >= 32'(N)) begin
                    n_result.status = dwt_pkg::ST_NO_FREE;
                end else begin
                    wr_en                 = 1'b1;
                    prot_en               = 1'b1;
                    wr_idx                = r_item.entry_index[dwt_pkg::IDX_W-1:0];
                    n_result.result_index = 4'(wr_idx);
                end
            end
            dwt_pkg::OP_RELEASE: begin
                rel_en = 1'b1;
            end
            default: begin
                rel_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_layout_v3 <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_layout_v3 <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_item <= i_item;
        if (i_cmd.eval) begin
            r_free      <= free_v;
            r_match     <= match_v;
            r_addr_mis  <= addr_mis;
            r_size_mis  <= size_mis;
            r_too_large <= too_large;
        end
        if (i_cmd.commit) r_result <= n_result;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prot <= '0;
            for (int i = 0; i < N; i++) begin
                r_page[i]  <= '0;
                r_pages[i] <= '0;
                r_flags[i] <= '0;
            end
        end else if (i_cmd.commit) begin
            for (int i = 0; i < N; i++) begin
                if (rel_en && !r_prot[i]) begin
                    r_page[i]  <= '0;
                    r_pages[i] <= '0;
                    r_flags[i] <= '0;
                end else if (wr_en && (wr_idx == dwt_pkg::IDX_W'(i))) begin
                    r_page[i]  <= wr_page;
                    r_pages[i] <= wr_pages;
                    r_flags[i] <= wr_flags;
                    if (prot_en) r_prot[i] <= (wr_flags != '0);
                end
            end
        end
    end

    assign o_result = r_result;

endmodule

[rtl/core/dma_window_table_top.sv]
// Top level of the DMA window table: controller plus datapath.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-----------------------------
//  item in  | start, busy               | i_item   (dwt_pkg::t_in_item)
//  result   | o_result_valid (strobe)   | o_result (dwt_pkg::t_out_item)
//  config   | i_cfg_wr_en               | i_cfg_wr_data (layout_v3)
//
// An item is taken when start is high and busy is low; it passes through
// capture, per-entry compare and commit, and its result strobes once the
// controller is back in idle, so the next item can be taken in that same cycle.
// Synchronous active-low reset clears the whole table, the protected mask
// and the layout register. The result is never stalled.
`timescale 1ns / 1ps

module dma_window_table_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  dwt_pkg::t_in_item   i_item,
    output logic                o_result_valid,
    output dwt_pkg::t_out_item  o_result,
    input  logic                i_cfg_wr_en,
    input  logic                i_cfg_wr_data
);

    dwt_pkg::t_dp_cmd cmd;

    dwt_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .o_result_valid (o_result_valid),
        .o_cmd          (cmd)
    );

    dwt_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_item        (i_item),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_result      (o_result)
    );

endmodule

[rtl/core/dwt_checker.sv]
// Port-level checker for the DMA window table, bound to the top level.
`timescale 1ns / 1ps

module dwt_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               o_result_valid,
    input dwt_pkg::t_out_item o_result
);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after an accepted item");

    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##3 o_result_valid)
        else $error("result missing three cycles after accept");

    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("result strobe while busy");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe longer than one cycle");

    a_err_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_result.status != dwt_pkg::ST_OK))
            |-> (o_result.result_index == 4'd0))
        else $error("nonzero index with error status");

endmodule

bind dma_window_table_top dwt_checker u_dwt_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_result_valid (o_result_valid),
    .o_result       (o_result)
);

[dv/tb_top.sv]
// Self-checking testbench for the DMA window table: directed and random table operations.
`timescale 1ns / 1ps

module tb_top;
    import dwt_pkg::*;

    logic      i_clk          = 1'b0;
    logic      i_rst_n        = 1'b0;
    logic      start          = 1'b0;
    logic      busy;
    t_in_item  i_item         = '0;
    logic      o_result_valid;
    t_out_item o_result;
    logic      i_cfg_wr_en    = 1'b0;
    logic      i_cfg_wr_data  = 1'b0;

    always #2 i_clk = ~i_clk;

    dma_window_table_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_item         (i_item),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data)
    );

    logic [PAGE_W-1:0]      tbl_page  [ENTRY_COUNT];
    logic [PAGES_W-1:0]     tbl_pages [ENTRY_COUNT];
    logic [FLAGS_W-1:0]     tbl_flags [ENTRY_COUNT];
    logic [ENTRY_COUNT-1:0] tbl_prot;
    logic                   tbl_layout_v3;

    t_out_item status_queue[$];
    t_out_item exp_res;
    int        err_cnt = 0;

    task automatic flag_error(input string msg);
        err_cnt++;
        if (err_cnt <= 10) begin
            $display("%s", msg);
        end
    endtask

    function automatic logic [FLAGS_W-1:0] kept_flags(input logic [FLAGS_W-1:0] f);
        return tbl_layout_v3 ? f : (f & 32'h0000_00FF);
    endfunction

    function automatic logic [CNT_W-1:0] page_limit();
        return tbl_layout_v3 ? CNT_W'(32'h3FFF_FFFF) : CNT_W'(32'h00FF_FFFF);
    endfunction

    function automatic t_out_item apply_table_op(input t_in_item it);
        t_out_item          r;
        int                 slot;
        logic [CNT_W-1:0]   cnt;
        logic [FLAGS_W-1:0] f;
        r    = '0;
        slot = -1;
        cnt  = it.entry_size[SIZE_W-1:PAGE_SHIFT];
        case (it.opcode)
            OP_ADD: begin
                for (int i = 0; i < ENTRY_COUNT; i++) begin
                    if (slot < 0 && !tbl_prot[i] && tbl_flags[i] == '0) slot = i;
                end
                if (slot < 0) begin
                    r.status = ST_NO_FREE;
                end else if (it.entry_address[PAGE_SHIFT-1:0] != '0) begin
                    r.status = ST_ADDR_MISALGN;
                end else if (it.entry_size[PAGE_SHIFT-1:0] != '0) begin
                    r.status = ST_SIZE_MISALGN;
                end else if (cnt > page_limit()) begin
                    r.status = ST_SIZE_LARGE;
                end else begin
                    tbl_page[slot]  = it.entry_address[ADDR_W-1:PAGE_SHIFT];
                    tbl_pages[slot] = PAGES_W'(cnt);
                    tbl_flags[slot] = kept_flags(it.entry_flags);
                    r.status        = ST_OK;
                    r.result_index  = 4'(slot);
                end
            end
            OP_REMOVE: begin
                for (int i = 0; i < ENTRY_COUNT; i++) begin
                    if (slot < 0 && {tbl_page[i], 12'h000} == it.entry_address
                        && {1'b0, tbl_pages[i], 12'h000} == it.entry_size
                        && tbl_flags[i] == it.entry_flags) slot = i;
                end
                if (slot < 0) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    tbl_page[slot]  = '0;
                    tbl_pages[slot] = '0;
                    tbl_flags[slot] = '0;
                    r.status        = ST_OK;
                    r.result_index  = 4'(slot);
                end
            end
            OP_PRELOAD: begin
                slot            = int'(it.entry_index);
                f               = kept_flags(it.entry_flags);
                tbl_page[slot]  = it.entry_address[ADDR_W-1:PAGE_SHIFT];
                tbl_pages[slot] = PAGES_W'(cnt & page_limit());
                tbl_flags[slot] = f;
                tbl_prot[slot]  = (f != '0);
                r.status        = ST_OK;
                r.result_index  = it.entry_index;
            end
            default: begin
                for (int i = 0; i < ENTRY_COUNT; i++) begin
                    if (!tbl_prot[i]) begin
                        tbl_page[i]  = '0;
                        tbl_pages[i] = '0;
                        tbl_flags[i] = '0;
                    end
                end
                r.status = ST_OK;
            end
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) begin
            if (status_queue.size() == 0) begin
                flag_error($sformatf("unexpected result: status %0d index %0d",
                                     o_result.status, o_result.result_index));
            end else begin
                exp_res = status_queue.pop_front();
                if (o_result.status !== exp_res.status
                    || o_result.result_index !== exp_res.result_index) begin
                    flag_error($sformatf("mismatch: status exp %0d act %0d, index exp %0d act %0d",
                                         exp_res.status, o_result.status,
                                         exp_res.result_index, o_result.result_index));
                end
            end
        end
    end

    // Hold start high across back-to-back items; drop it only for a gap.
    task automatic send_item(input t_in_item it, input int gap);
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        status_queue.push_back(apply_table_op(it));
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (status_queue.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_layout(input logic v3);
        drain();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v3;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        tbl_layout_v3 = v3;
        @(posedge i_clk);
    endtask

    function automatic t_in_item mk_item(input logic [1:0] op, input logic [3:0] idx,
                                         input logic [ADDR_W-1:0] addr,
                                         input logic [SIZE_W-1:0] size,
                                         input logic [FLAGS_W-1:0] flags);
        t_in_item it;
        it.opcode        = op;
        it.entry_index   = idx;
        it.entry_address = addr;
        it.entry_size    = size;
        it.entry_flags   = flags;
        return it;
    endfunction

    function automatic int idle_cycles(input int pct);
        int n = 0;
        while (n < 20 && $urandom_range(0, 99) < pct) n++;
        return n;
    endfunction

    function automatic logic [FLAGS_W-1:0] rand_flags();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return '0;
        if (r < 30) return '1;
        return $urandom;
    endfunction

    function automatic t_in_item rand_item();
        t_in_item         it;
        int               r;
        int               k;
        logic [CNT_W-1:0] cnt;
        it.opcode        = OP_ADD;
        it.entry_index   = 4'($urandom);
        it.entry_address = ADDR_W'({$urandom, $urandom});
        it.entry_size    = SIZE_W'({$urandom, $urandom});
        it.entry_flags   = rand_flags();
        r = $urandom_range(0, 99);
        if (r < 90) begin
            it.entry_address[PAGE_SHIFT-1:0] = '0;
        end
        k = $urandom_range(0, 99);
        if (k < 40) begin
            cnt = CNT_W'($urandom_range(0, 16));
        end else if (k < 75) begin
            cnt = CNT_W'($urandom) & page_limit();
        end else begin
            cnt = CNT_W'(page_limit() + 1 + (CNT_W'($urandom) & page_limit()));
        end
        if (k < 90) begin
            it.entry_size = {cnt, 12'h000};
        end
        if ($urandom_range(0, 99) < 8) begin
            it.entry_size[PAGE_SHIFT-1:0] = 12'($urandom_range(1, 4095));
        end
        r = $urandom_range(0, 99);
        if (r < 45) begin
            it.opcode = OP_ADD;
        end else if (r < 72) begin
            it.opcode = OP_REMOVE;
            if ($urandom_range(0, 99) < 80) begin
                k                = $urandom_range(0, ENTRY_COUNT - 1);
                it.entry_address = {tbl_page[k], 12'h000};
                it.entry_size    = {1'b0, tbl_pages[k], 12'h000};
                it.entry_flags   = tbl_flags[k];
                if ($urandom_range(0, 9) == 0) begin
                    it.entry_flags[$urandom_range(0, FLAGS_W - 1)] ^= 1'b1;
                end
            end
        end else if (r < 92) begin
            it.opcode = OP_PRELOAD;
            if ($urandom_range(0, 1) == 0) it.entry_flags = '0;
        end else begin
            it.opcode = OP_RELEASE;
        end
        return it;
    endfunction

    task automatic test_add_checks();
        write_layout(1'b0);
        send_item(mk_item(OP_ADD, 4'hF, 44'hFFF_FFFF_F000, {31'h00FF_FFFF, 12'h000}, '1), 0);
        send_item(mk_item(OP_ADD, 4'h0, 44'h000_0000_1001, 43'h1000, 32'h1), 1);
        send_item(mk_item(OP_ADD, 4'h0, 44'h0, 43'h1800, 32'h1), 0);
        send_item(mk_item(OP_ADD, 4'h0, 44'h0, {31'h0100_0000, 12'h000}, 32'h1), 2);
        send_item(mk_item(OP_ADD, 4'h0, 44'h123, 43'h7FF_FFFF_FFFF, 32'h1), 0);
        send_item(mk_item(OP_ADD, 4'h0, 44'h5000, 43'h2000, 32'h0), 0);
        send_item(mk_item(OP_ADD, 4'h0, 44'h5000, 43'h2000, 32'h1), 3);
        send_item(mk_item(OP_ADD, 4'h0, 44'h0, 43'h0, 32'h80), 0);
        drain();
    endtask

    task automatic test_remove();
        send_item(mk_item(OP_REMOVE, 4'h0, 44'hFFF_FFFF_F000, {31'h00FF_FFFF, 12'h000},
                          32'hFF), 0);
        send_item(mk_item(OP_REMOVE, 4'h0, 44'h5000, 43'h2000, 32'h101), 1);
        send_item(mk_item(OP_REMOVE, 4'h0, 44'h5000, 43'h2000, 32'h1), 0);
        send_item(mk_item(OP_REMOVE, 4'h0, 44'h0, 43'h0, 32'h0), 0);
        send_item(mk_item(OP_REMOVE, 4'h0, 44'h1000, 43'h1000, 32'h7), 2);
        drain();
    endtask

    task automatic test_preload_release();
        send_item(mk_item(OP_PRELOAD, 4'hF, 44'h0AB_CDE1_2123, 43'h7FF_FFFF_FFFF,
                          32'h1234_5600), 0);
        send_item(mk_item(OP_PRELOAD, 4'hF, 44'h0AB_CDE1_2000, 43'h4000, 32'h3C), 0);
        send_item(mk_item(OP_PRELOAD, 4'h3, 44'h7000, 43'h3000, 32'hFF), 1);
        send_item(mk_item(OP_REMOVE, 4'h0, 44'h7000, 43'h3000, 32'hFF), 0);
        send_item(mk_item(OP_RELEASE, 4'h9, '1, '1, '1), 0);
        send_item(mk_item(OP_ADD, 4'h0, 44'h9000, 43'h1000, 32'h2), 2);
        send_item(mk_item(OP_PRELOAD, 4'h3, 44'h0, 43'h0, 32'h0), 0);
        drain();
    endtask

    task automatic test_layout_v3();
        write_layout(1'b1);
        send_item(mk_item(OP_ADD, 4'h0, 44'h800_0000_0000, {31'h3FFF_FFFF, 12'h000}, '1), 0);
        send_item(mk_item(OP_ADD, 4'h0, 44'h0, {31'h4000_0000, 12'h000}, '1), 0);
        send_item(mk_item(OP_REMOVE, 4'h0, 44'h800_0000_0000, {31'h3FFF_FFFF, 12'h000},
                          '1), 1);
        send_item(mk_item(OP_PRELOAD, 4'h7, 44'hFFF_FFFF_FFFF, 43'h7FF_FFFF_F000,
                          32'h1234_5600), 0);
        send_item(mk_item(OP_RELEASE, 4'h0, '0, '0, '0), 0);
        drain();
    endtask

    task automatic test_random(input int n, input int pct, input logic v3);
        write_layout(v3);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 149) == 0) drain();
            send_item(rand_item(), idle_cycles(pct));
        end
        drain();
    endtask

    initial begin
        for (int i = 0; i < ENTRY_COUNT; i++) begin
            tbl_page[i]  = '0;
            tbl_pages[i] = '0;
            tbl_flags[i] = '0;
        end
        tbl_prot      = '0;
        tbl_layout_v3 = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_add_checks();
        test_remove();
        test_preload_release();
        test_layout_v3();
        test_random(270, 30, 1'b0);
        test_random(270, 30, 1'b1);
        test_random(270, 53, 1'b0);
        test_random(270, 53, 1'b1);
        test_random(260, 0, 1'b1);
        test_random(260, 0, 1'b0);
        drain();
        repeat (10) @(posedge i_clk);
        if (status_queue.size() != 0) begin
            flag_error($sformatf("%0d results never arrived", status_queue.size()));
        end
        if (err_cnt == 0) begin
            $display("[dma_window_table_top] OK");
        end else begin
            $display("[dma_window_table_top] ERROR");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("[dma_window_table_top] ERROR");
        $finish;
    end

endmodule
